// ===== rtl/rmsi_pkg.sv =====
// ----------------------------------------------------------------------------
// rmsi_pkg
// Shared widths, sizing default and cell control types for the running
// median block.
// ----------------------------------------------------------------------------
package rmsi_pkg;

    localparam int CAPACITY = 1024;
    localparam int SAMPLE_W = 32;
    localparam int MEDIAN_W = 33;
    localparam int COUNT_W  = 11;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_PUSH   = 2'd2,
        OP_POP    = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t                    op;
        logic signed [SAMPLE_W-1:0]  din;
    } chain_ctrl_t;

endpackage

// ===== rtl/running_median_sorted_insert.sv =====
// ----------------------------------------------------------------------------
// running_median_sorted_insert
// Running median of a stream of signed 32-bit samples.
// ----------------------------------------------------------------------------
// The input channel (in_valid, in_stall, sample) takes one sample per
// transfer. The output channel (out_valid, out_stall) returns one result per
// sample: median_twice (twice the median, exact), count and dropped.
// Samples live in two cell chains split at the median: the lower half with
// its largest sample at the head, the upper half with its smallest at the
// head, so the median is always read from the two head cells.
// Timing: the transfer inserts the sample into one chain and enters the
// rebalance state, which moves one head across and loads the result
// register once no held result is stalled. The input is stalled meanwhile,
// so a new sample is taken only after the previous one is rebalanced.
// Once the store holds CAPACITY samples, new samples are discarded with
// dropped set and the median of the unchanged store reported.
// Reset empties the store (count zero); no clearing pass is needed.
// When the receiver stalls, the result register holds. One more sample is
// still taken and inserted, and its rebalance waits until the held result
// is transferred.
// ----------------------------------------------------------------------------
module running_median_sorted_insert #(
    parameter int CAPACITY = rmsi_pkg::CAPACITY
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [rmsi_pkg::SAMPLE_W-1:0]  sample,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [rmsi_pkg::MEDIAN_W-1:0]  median_twice,
    output logic [rmsi_pkg::COUNT_W-1:0]          count,
    output logic                                  dropped
);

    localparam int HALF = CAPACITY / 2 + 1;
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int LW   = $clog2(HALF + 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_BAL  = 2'b10
    } state_t;

    state_t                                state_reg, state_next;
    logic [CW-1:0]                         n_reg, n_next;
    logic [LW-1:0]                         lcnt_reg, lcnt_next;
    logic [LW-1:0]                         ucnt_reg, ucnt_next;
    logic                                  drop_reg, drop_next;
    logic                                  out_valid_reg, out_valid_next;
    logic signed [rmsi_pkg::MEDIAN_W-1:0]  median_reg, median_next;
    logic [rmsi_pkg::COUNT_W-1:0]          count_reg, count_next;
    logic                                  dropped_reg, dropped_next;

    rmsi_pkg::chain_ctrl_t                 lctrl, uctrl;
    logic signed [rmsi_pkg::SAMPLE_W-1:0]  lhead, lsec, uhead, usec;
    logic signed [rmsi_pkg::SAMPLE_W-1:0]  lh_new, uh_new;
    logic                                  accept, full, to_low;
    logic                                  move_up, move_down;
    logic [CW:0]                           n_plus;
    logic [LW-1:0]                         target;

    rmsi_chain #(
        .DEPTH  (HALF),
        .CNT_W  (LW),
        .ASCEND (1'b0)
    ) u_low (
        .clk    (clk),
        .ctrl   (lctrl),
        .cnt    (lcnt_reg),
        .head   (lhead),
        .second (lsec)
    );

    rmsi_chain #(
        .DEPTH  (HALF),
        .CNT_W  (LW),
        .ASCEND (1'b1)
    ) u_high (
        .clk    (clk),
        .ctrl   (uctrl),
        .cnt    (ucnt_reg),
        .head   (uhead),
        .second (usec)
    );

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign full     = (n_reg == CW'(CAPACITY));
    assign to_low   = (lcnt_reg == '0) || (sample <= lhead);

    // lower half keeps ceil(n/2) samples
    assign n_plus    = {1'b0, n_reg} + (CW + 1)'(1);
    assign target    = LW'(n_plus >> 1);
    assign move_up   = lcnt_reg > target;
    assign move_down = lcnt_reg < target;

    assign lh_new = move_down ? uhead : (move_up ? lsec : lhead);
    assign uh_new = move_up ? lhead : (move_down ? usec : uhead);

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        lcnt_next      = lcnt_reg;
        ucnt_next      = ucnt_reg;
        drop_next      = drop_reg;
        median_next    = median_reg;
        count_next     = count_reg;
        dropped_next   = dropped_reg;
        out_valid_next = out_valid_reg && out_stall;
        lctrl.op       = rmsi_pkg::OP_HOLD;
        lctrl.din      = sample;
        uctrl.op       = rmsi_pkg::OP_HOLD;
        uctrl.din      = sample;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_BAL;
                    drop_next  = full;
                    if (!full)
                    begin
                        n_next = n_reg + CW'(1);
                        if (to_low)
                        begin
                            lctrl.op  = rmsi_pkg::OP_INSERT;
                            lcnt_next = lcnt_reg + LW'(1);
                        end
                        else
                        begin
                            uctrl.op  = rmsi_pkg::OP_INSERT;
                            ucnt_next = ucnt_reg + LW'(1);
                        end
                    end
                end
            end
            ST_BAL:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = ST_IDLE;
                    if (move_up)
                    begin
                        lctrl.op  = rmsi_pkg::OP_POP;
                        uctrl.op  = rmsi_pkg::OP_PUSH;
                        uctrl.din = lhead;
                        lcnt_next = lcnt_reg - LW'(1);
                        ucnt_next = ucnt_reg + LW'(1);
                    end
                    else if (move_down)
                    begin
                        uctrl.op  = rmsi_pkg::OP_POP;
                        lctrl.op  = rmsi_pkg::OP_PUSH;
                        lctrl.din = uhead;
                        ucnt_next = ucnt_reg - LW'(1);
                        lcnt_next = lcnt_reg + LW'(1);
                    end

                    if (n_reg == '0)
                    begin
                        median_next = '0;
                    end
                    else if (n_reg[0])
                    begin
                        median_next = {lh_new, 1'b0};
                    end
                    else
                    begin
                        median_next = {lh_new[rmsi_pkg::SAMPLE_W-1], lh_new}
                                    + {uh_new[rmsi_pkg::SAMPLE_W-1], uh_new};
                    end
                    count_next     = rmsi_pkg::COUNT_W'(n_reg);
                    dropped_next   = drop_reg;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            n_reg         <= '0;
            lcnt_reg      <= '0;
            ucnt_reg      <= '0;
            drop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            lcnt_reg      <= lcnt_next;
            ucnt_reg      <= ucnt_next;
            drop_reg      <= drop_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        median_reg  <= median_next;
        count_reg   <= count_next;
        dropped_reg <= dropped_next;
    end

    assign out_valid    = out_valid_reg;
    assign median_twice = median_reg;
    assign count        = count_reg;
    assign dropped      = dropped_reg;

endmodule

// ===== rtl/rmsi_cell.sv =====
// ----------------------------------------------------------------------------
// rmsi_cell
// One storage cell of a sorted chain: compare against the incoming value and
// keep, take the neighbor's value or take the new value.
// ----------------------------------------------------------------------------
module rmsi_cell #(
    parameter bit ASCEND = 1'b1
) (
    input  logic                                  clk,
    input  rmsi_pkg::chain_ctrl_t                 ctrl,
    input  logic                                  occ,
    input  logic signed [rmsi_pkg::SAMPLE_W-1:0]  prev_val,
    input  logic                                  prev_ge,
    input  logic signed [rmsi_pkg::SAMPLE_W-1:0]  next_val,
    output logic signed [rmsi_pkg::SAMPLE_W-1:0]  val,
    output logic                                  ge
);

    logic signed [rmsi_pkg::SAMPLE_W-1:0] val_reg;
    logic signed [rmsi_pkg::SAMPLE_W-1:0] val_next;
    logic                                 cmp;

    // new value belongs at or before this cell
    assign cmp = ASCEND ? (val_reg >= ctrl.din) : (val_reg <= ctrl.din);
    assign ge  = !occ || cmp;

    always_comb
    begin
        val_next = val_reg;
        case (ctrl.op)
            rmsi_pkg::OP_HOLD:
            begin
                val_next = val_reg;
            end
            rmsi_pkg::OP_INSERT:
            begin
                if (ge)
                begin
                    val_next = prev_ge ? prev_val : ctrl.din;
                end
            end
            rmsi_pkg::OP_PUSH:
            begin
                val_next = prev_val;
            end
            rmsi_pkg::OP_POP:
            begin
                val_next = next_val;
            end
            default:
            begin
                val_next = val_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val = val_reg;

endmodule

// ===== rtl/rmsi_chain.sv =====
// ----------------------------------------------------------------------------
// rmsi_chain
// Row of cells holding one half of the samples in sorted order, head first:
// insert in place, push at the head or pop the head.
// ----------------------------------------------------------------------------
module rmsi_chain #(
    parameter int DEPTH  = 513,
    parameter int CNT_W  = 10,
    parameter bit ASCEND = 1'b1
) (
    input  logic                                  clk,
    input  rmsi_pkg::chain_ctrl_t                 ctrl,
    input  logic [CNT_W-1:0]                      cnt,
    output logic signed [rmsi_pkg::SAMPLE_W-1:0]  head,
    output logic signed [rmsi_pkg::SAMPLE_W-1:0]  second
);

    logic signed [rmsi_pkg::SAMPLE_W-1:0] vals [DEPTH];
    logic                                 ges  [DEPTH];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [rmsi_pkg::SAMPLE_W-1:0] prev_val;
        logic signed [rmsi_pkg::SAMPLE_W-1:0] next_val;
        logic                                 prev_ge;
        logic                                 occ;

        assign occ = cnt > CNT_W'(i);

        // the head cell sees the incoming value as its left neighbor
        if (i == 0)
        begin : g_head
            assign prev_val = ctrl.din;
            assign prev_ge  = 1'b0;
        end
        else
        begin : g_body
            assign prev_val = vals[i-1];
            assign prev_ge  = ges[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign next_val = vals[i];
        end
        else
        begin : g_mid
            assign next_val = vals[i+1];
        end

        rmsi_cell #(
            .ASCEND (ASCEND)
        ) u_cell (
            .clk      (clk),
            .ctrl     (ctrl),
            .occ      (occ),
            .prev_val (prev_val),
            .prev_ge  (prev_ge),
            .next_val (next_val),
            .val      (vals[i]),
            .ge       (ges[i])
        );
    end

    assign head   = vals[0];
    assign second = vals[1];

endmodule

// ===== rtl/rmsi_check.sv =====
// ----------------------------------------------------------------------------
// rmsi_check
// Port-level checks for the running median block, bound to the top level.
// ----------------------------------------------------------------------------
module rmsi_check #(
    parameter int CAPACITY = rmsi_pkg::CAPACITY
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    input  logic                                  in_stall,
    input  logic                                  out_valid,
    input  logic                                  out_stall,
    input  logic signed [rmsi_pkg::MEDIAN_W-1:0]  median_twice,
    input  logic [rmsi_pkg::COUNT_W-1:0]          count,
    input  logic                                  dropped
);

    localparam logic [rmsi_pkg::COUNT_W-1:0] FULL_COUNT = rmsi_pkg::COUNT_W'(CAPACITY);

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(median_twice)
            && $stable(count) && $stable(dropped))
        else $error("result changed while stalled");

    // the cycle after a transfer in is spent rebalancing
    a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken during rebalance");

    // odd count means the median is one sample, so twice it is even
    a_odd_even: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && count[0] |-> !median_twice[0])
        else $error("odd count with fractional median");

    // a discarded sample only happens on a full store
    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && dropped |-> count == FULL_COUNT)
        else $error("sample dropped below capacity");

    // every result follows at least one stored sample
    a_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> count != '0 || CAPACITY >= (1 << rmsi_pkg::COUNT_W))
        else $error("result with empty store");

endmodule

bind running_median_sorted_insert rmsi_check #(
    .CAPACITY (CAPACITY)
) u_rmsi_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .median_twice (median_twice),
    .count        (count),
    .dropped      (dropped)
);

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for running_median_sorted_insert. A directed table
// covers the sample extremes, equal samples and alternating bit patterns.
// Random samples follow, enough to fill the store and run well past it into
// the dropped-sample case. Every result is checked against a sorted-queue
// model or a typed value. The sender works in bursts, the receiver stalls on
// its own pattern, and one long receiver hold backs the block up.
// ----------------------------------------------------------------------------
module tb;

    localparam int N_DIRECTED = 20;
    localparam int N_RANDOM   = 1880;
    localparam int IDLE_LIMIT = 2000;
    localparam int HOLD_LEN   = 400;
    localparam int HOLD_AFTER = 300;

    typedef struct packed {
        logic signed [rmsi_pkg::MEDIAN_W-1:0] median_twice;
        logic [rmsi_pkg::COUNT_W-1:0]         count;
        logic                                 dropped;
    } median_result_t;

    typedef struct packed {
        logic signed [rmsi_pkg::SAMPLE_W-1:0] value;
        logic                                 typed;
        median_result_t                       res;
    } directed_row_t;

    logic                                 clk       = 1'b0;
    logic                                 rst_n     = 1'b0;
    logic                                 in_valid  = 1'b0;
    logic                                 in_stall;
    logic signed [rmsi_pkg::SAMPLE_W-1:0] sample    = '0;
    logic                                 out_valid;
    logic                                 out_stall = 1'b0;
    logic signed [rmsi_pkg::MEDIAN_W-1:0] median_twice;
    logic [rmsi_pkg::COUNT_W-1:0]         count;
    logic                                 dropped;

    // sorted copy of the samples the block should hold
    int             sorted_samples[$];
    median_result_t expected_q[$];
    bit             mismatch_seen   = 1'b0;
    int             samples_taken   = 0;
    int             idle_cycles     = 0;
    int             burst_left      = 0;

    // expected value typed in only where it can be read off at a glance
    directed_row_t directed_rows [N_DIRECTED] = '{
        '{32'sh8000_0000, 1'b1, '{33'h1_0000_0000, 11'd1, 1'b0}},
        '{32'sh7FFF_FFFF, 1'b1, '{33'h1_FFFF_FFFF, 11'd2, 1'b0}},
        '{32'sh0000_0000, 1'b1, '{33'h0_0000_0000, 11'd3, 1'b0}},
        '{32'sh7FFF_FFFF, 1'b1, '{33'h0_7FFF_FFFF, 11'd4, 1'b0}},
        '{32'sh7FFF_FFFF, 1'b1, '{33'h0_FFFF_FFFE, 11'd5, 1'b0}},
        '{32'sh8000_0000, 1'b1, '{33'h0_7FFF_FFFF, 11'd6, 1'b0}},
        '{32'shFFFF_FFFF, 1'b1, '{33'h0_0000_0000, 11'd7, 1'b0}},
        '{32'sh0000_0000, 1'b0, '0},
        '{32'sh0000_0000, 1'b0, '0},
        '{32'shFFFF_FFFF, 1'b0, '0},
        '{32'sh0000_0001, 1'b0, '0},
        '{32'sh5555_5555, 1'b0, '0},
        '{32'shAAAA_AAAA, 1'b0, '0},
        '{32'sh0000_FFFF, 1'b0, '0},
        '{32'shFFFF_0000, 1'b0, '0},
        '{32'sh0000_0005, 1'b0, '0},
        '{32'sh0000_0005, 1'b0, '0},
        '{32'shFFFF_FFFA, 1'b0, '0},
        '{32'sh7FFF_FFFE, 1'b0, '0},
        '{32'sh8000_0001, 1'b0, '0}
    };

    running_median_sorted_insert i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample       (sample),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .median_twice (median_twice),
        .count        (count),
        .dropped      (dropped)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // insert into the sorted store unless it is full, then report the median
    function automatic median_result_t insert_and_median(
        logic signed [rmsi_pkg::SAMPLE_W-1:0] value);
        median_result_t res;
        int             pos;
        int             n;
        longint         twice;
        res.dropped = 1'b0;
        if (sorted_samples.size() >= rmsi_pkg::CAPACITY)
        begin
            res.dropped = 1'b1;
        end
        else
        begin
            pos = 0;
            while (pos < sorted_samples.size() && sorted_samples[pos] < value)
                pos++;
            sorted_samples.insert(pos, value);
        end
        n = sorted_samples.size();
        if (n % 2 == 1)
            twice = 2 * longint'(sorted_samples[n / 2]);
        else
            twice = longint'(sorted_samples[n / 2 - 1]) + longint'(sorted_samples[n / 2]);
        res.median_twice = twice[rmsi_pkg::MEDIAN_W-1:0];
        res.count        = n[rmsi_pkg::COUNT_W-1:0];
        return res;
    endfunction

    function automatic logic signed [rmsi_pkg::SAMPLE_W-1:0] random_sample();
        logic signed [rmsi_pkg::SAMPLE_W-1:0] v;
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 4))
                    0:       v = 32'sh8000_0000;
                    1:       v = 32'sh7FFF_FFFF;
                    2:       v = 32'sh0000_0000;
                    3:       v = 32'shFFFF_FFFF;
                    default: v = 32'sh0000_0001;
                endcase
            end
            1, 2:
            begin
                // narrow range, plenty of equal samples
                v = $urandom_range(0, 16);
                v = v - 8;
            end
            3, 4:
            begin
                v = $urandom_range(0, 2000);
                v = v - 1000;
            end
            default:
                v = $urandom();
        endcase
        return v;
    endfunction

    // offer one sample in bursts with random gaps, record the expectation on transfer
    task automatic offer_sample(input logic signed [rmsi_pkg::SAMPLE_W-1:0] value,
                                input logic typed, input median_result_t typed_res);
        median_result_t res;
        int             gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        sample   <= value;
        do
            @(posedge clk);
        while (in_stall);
        res = insert_and_median(value);
        expected_q.push_back(typed ? typed_res : res);
    endtask

    initial
    begin : stimulus
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed_rows[i])
            offer_sample(directed_rows[i].value, directed_rows[i].typed, directed_rows[i].res);
        repeat (N_RANDOM)
            offer_sample(random_sample(), 1'b0, '0);
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (!mismatch_seen)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin : receiver
        int  run_len;
        int  mode;
        bit  hold_done;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            // one long hold so the block fills up and stalls its input
            if (!hold_done && samples_taken >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_LEN) @(posedge clk);
            end
            mode    = $urandom_range(0, 3);
            run_len = $urandom_range(5, 60);
            repeat (run_len)
            begin
                case (mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 3) == 0);
                    2:       out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= ~out_stall;
                endcase
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        median_result_t exp_res;
        bit             moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (in_valid && !in_stall)
            begin
                samples_taken++;
                moved = 1'b1;
            end
            if (out_valid && !out_stall)
            begin
                moved = 1'b1;
                if (expected_q.size() == 0)
                begin
                    $error("unexpected result: median_twice %0d count %0d dropped %0d",
                           $signed(median_twice), count, dropped);
                    mismatch_seen = 1'b1;
                end
                else
                begin
                    exp_res = expected_q.pop_front();
                    if (median_twice !== exp_res.median_twice)
                    begin
                        $error("median_twice: expected %0d, actual %0d",
                               $signed(exp_res.median_twice), $signed(median_twice));
                        mismatch_seen = 1'b1;
                    end
                    if (count !== exp_res.count)
                    begin
                        $error("count: expected %0d, actual %0d", exp_res.count, count);
                        mismatch_seen = 1'b1;
                    end
                    if (dropped !== exp_res.dropped)
                    begin
                        $error("dropped: expected %0d, actual %0d", exp_res.dropped, dropped);
                        mismatch_seen = 1'b1;
                    end
                end
            end
            // watchdog on cycles without any transfer
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

endmodule
